// ===== design/spmq_pkg.sv =====
// Package for the strict priority multi-queue unit: field widths, command and
// status codes, default sizes and the controller-to-datapath command bundle.
// Depends on nothing.
`default_nettype none

package spmq_pkg;

  // Default sizes of the queue storage.
  localparam int LEVELS_DEFAULT = 8;
  localparam int DEPTH_DEFAULT  = 16;

  // Fixed widths of the item fields.
  localparam int CMD_W    = 2;
  localparam int TASK_W   = 16;
  localparam int PRIO_W   = 4;
  localparam int STATUS_W = 2;
  localparam int TOTAL_W  = 8;
  localparam int LCOUNT_W = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_PEEK   = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // One strobe per datapath step, driven by the controller.
  typedef struct packed {
    logic capture;
    logic select;
    logic access;
    logic report;
  } ctrl_cmd_t;

endpackage

`default_nettype wire

// ===== design/spmq_ram.sv =====
// Generic single-port RAM with a registered read, used for the task storage.
// Depends on nothing.
`default_nettype none

module spmq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ===== design/spmq_ctrl.sv =====
// Controller of the strict priority multi-queue unit: sequences each item
// through select, access and report steps. Depends on spmq_pkg.
`default_nettype none

module spmq_ctrl
  import spmq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  output logic      done,
  output ctrl_cmd_t ctrl
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SELECT,
    S_ACCESS,
    S_REPORT
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_SELECT;
            busy  <= 1'b1;
          end
        end
        S_SELECT: begin
          state <= S_ACCESS;
        end
        S_ACCESS: begin
          state <= S_REPORT;
        end
        S_REPORT: begin
          state <= S_IDLE;
          busy  <= 1'b0;
          done  <= 1'b1;
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    ctrl.capture = (state == S_IDLE) && start;
    ctrl.select  = (state == S_SELECT);
    ctrl.access  = (state == S_ACCESS);
    ctrl.report  = (state == S_REPORT);
  end

endmodule

`default_nettype wire

// ===== design/spmq_datapath.sv =====
// Datapath of the strict priority multi-queue unit: per-level ring pointers
// and fill counts, the level selector, the task storage and the result
// registers. Depends on spmq_pkg and spmq_ram.
`default_nettype none

module spmq_datapath
  import spmq_pkg::*;
#(
  parameter int NUM_LEVELS  = LEVELS_DEFAULT,
  parameter int LEVEL_DEPTH = DEPTH_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ctrl_cmd_t           ctrl,
  input  wire logic [CMD_W-1:0]    cmd,
  input  wire logic [TASK_W-1:0]   task_id,
  input  wire logic [PRIO_W-1:0]   priority_req,
  output logic      [STATUS_W-1:0] status,
  output logic      [TASK_W-1:0]   out_task_id,
  output logic      [PRIO_W-1:0]   out_priority,
  output logic                     all_empty,
  output logic      [TOTAL_W-1:0]  total_count,
  output logic      [LCOUNT_W-1:0] level_count
);

  localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int IW = $clog2(LEVEL_DEPTH);
  localparam int FW = $clog2(LEVEL_DEPTH + 1);
  localparam int SW = FW + 1;
  localparam int SLOTS = NUM_LEVELS * LEVEL_DEPTH;
  localparam int AW = $clog2(SLOTS);
  localparam int TW = $clog2(SLOTS + 1);

  // Captured item.
  cmd_t              cmd_q;
  logic [TASK_W-1:0] tid_q;
  logic [PRIO_W-1:0] preq_q;

  // Per-level ring state.
  logic [IW-1:0] head [NUM_LEVELS];
  logic [FW-1:0] fill [NUM_LEVELS];
  logic [TW-1:0] total;

  logic [LW-1:0] lv;
  logic          found;
  logic          rd_ok_q;
  status_t       st_q;

  logic [PRIO_W-1:0] preq_m1;
  logic [LW-1:0]     preq_lv;
  logic              preq_valid;
  logic [LW-1:0]     top;
  logic              any_held;
  logic [LW-1:0]     rd_idx;
  logic [IW-1:0]     head_rd;
  logic [FW-1:0]     fill_rd;
  logic              add_ok;
  logic              rd_ok;
  logic [SW-1:0]     pos_sum;
  logic [IW-1:0]     tail_pos;
  logic [IW-1:0]     slot;
  logic [AW-1:0]     ram_addr;
  logic              ram_we;
  logic [TASK_W-1:0] ram_rdata;

  assign preq_m1    = preq_q - PRIO_W'(1);
  assign preq_lv    = LW'(preq_m1);
  assign preq_valid = (preq_q != '0) && (int'(preq_q) <= NUM_LEVELS);

  // Most urgent non-empty level: lowest index wins.
  always_comb begin
    top      = '0;
    any_held = 1'b0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (fill[i] != '0) begin
        top      = LW'(i);
        any_held = 1'b1;
      end
    end
  end

  // One read port on the level state, chosen by step.
  assign rd_idx  = ctrl.report ? preq_lv : lv;
  assign head_rd = head[rd_idx];
  assign fill_rd = fill[rd_idx];

  assign add_ok = (cmd_q == CMD_ADD) && found && (fill_rd < FW'(LEVEL_DEPTH));
  assign rd_ok  = ((cmd_q == CMD_PEEK) || (cmd_q == CMD_REMOVE)) && found;

  // Tail position; head plus fill stays below twice the depth.
  always_comb begin
    pos_sum = SW'(head_rd) + SW'(fill_rd);
    if (pos_sum >= SW'(LEVEL_DEPTH)) begin
      tail_pos = IW'(pos_sum - SW'(LEVEL_DEPTH));
    end else begin
      tail_pos = IW'(pos_sum);
    end
  end

  assign slot     = (cmd_q == CMD_ADD) ? tail_pos : head_rd;
  assign ram_addr = AW'(lv) * AW'(LEVEL_DEPTH) + AW'(slot);
  assign ram_we   = ctrl.access && add_ok;

  spmq_ram #(
    .WIDTH (TASK_W),
    .DEPTH (SLOTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (tid_q),
    .rdata (ram_rdata)
  );

  // Item capture and level selection.
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      cmd_q  <= cmd_t'(cmd);
      tid_q  <= task_id;
      preq_q <= priority_req;
    end
    if (ctrl.select) begin
      if ((cmd_q == CMD_PEEK) || (cmd_q == CMD_REMOVE)) begin
        lv    <= top;
        found <= any_held;
      end else begin
        lv    <= preq_lv;
        found <= preq_valid;
      end
    end
    if (ctrl.access) begin
      rd_ok_q <= rd_ok;
      priority case (1'b1)
        (cmd_q == CMD_ADD):                       st_q <= add_ok ? ST_OK : ST_FULL;
        (cmd_q == CMD_PEEK) || (cmd_q == CMD_REMOVE): st_q <= found ? ST_OK : ST_EMPTY;
        default:                                  st_q <= ST_OK;
      endcase
    end
  end

  // Ring pointers, fill counts and the running total.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head[i] <= '0;
        fill[i] <= '0;
      end
      total <= '0;
    end else if (ctrl.access) begin
      if (add_ok) begin
        fill[lv] <= fill_rd + FW'(1);
        total    <= total + TW'(1);
      end else if (rd_ok && (cmd_q == CMD_REMOVE)) begin
        fill[lv] <= fill_rd - FW'(1);
        head[lv] <= (head_rd == IW'(LEVEL_DEPTH - 1)) ? '0 : head_rd + IW'(1);
        total    <= total - TW'(1);
      end
    end
  end

  // Result registers, loaded once the storage read data is back.
  always_ff @(posedge clk) begin
    if (ctrl.report) begin
      status       <= st_q;
      out_task_id  <= rd_ok_q ? ram_rdata : '0;
      out_priority <= rd_ok_q ? PRIO_W'(32'(lv) + 32'd1) : '0;
      all_empty    <= (total == '0);
      total_count  <= TOTAL_W'(total);
      level_count  <= preq_valid ? LCOUNT_W'(fill_rd) : '0;
    end
  end

endmodule

`default_nettype wire

// ===== design/strict_priority_multi_queue_unit.sv =====
// Top level of the strict priority multi-queue unit: a controller and a
// datapath joined by a command bundle. Depends on spmq_pkg, spmq_ctrl and
// spmq_datapath (which holds the spmq_ram storage).
//
//   Channel  | Handshake              | Payload
//   ---------+------------------------+---------------------------------------
//   command  | start, busy            | cmd, task_id, priority_req
//   result   | done (one-cycle strobe)| status, out_task_id, out_priority,
//            |                        | all_empty, total_count, level_count
//
// An item is taken at a rising edge where start is high and busy is low. It
// then runs through select, access and report steps; done pulses for one cycle
// once the report step ends, and busy falls in that same cycle, so a new item
// can be taken there; no new item is taken while one is in flight. These steps
// are set by the single storage port and its registered read after the level
// has been chosen. The receiver cannot stall; results stay on the ports until
// the next item reports. Reset (rst, synchronous) empties every level at once;
// the task storage itself is never cleared and needs no clearing pass.
`default_nettype none

module strict_priority_multi_queue_unit
  import spmq_pkg::*;
#(
  parameter int NUM_LEVELS  = LEVELS_DEFAULT,
  parameter int LEVEL_DEPTH = DEPTH_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [CMD_W-1:0]    cmd,
  input  wire logic [TASK_W-1:0]   task_id,
  input  wire logic [PRIO_W-1:0]   priority_req,
  output logic                     done,
  output logic      [STATUS_W-1:0] status,
  output logic      [TASK_W-1:0]   out_task_id,
  output logic      [PRIO_W-1:0]   out_priority,
  output logic                     all_empty,
  output logic      [TOTAL_W-1:0]  total_count,
  output logic      [LCOUNT_W-1:0] level_count
);

  // The controller steps each item; the datapath acts on each step strobe.
  ctrl_cmd_t ctrl;

  spmq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .ctrl  (ctrl)
  );

  // The datapath captures the item, picks the level (the requested one for an
  // add, the most urgent non-empty one for peek and remove), performs the one
  // storage access and loads the result registers.
  spmq_datapath #(
    .NUM_LEVELS  (NUM_LEVELS),
    .LEVEL_DEPTH (LEVEL_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .cmd          (cmd),
    .task_id      (task_id),
    .priority_req (priority_req),
    .status       (status),
    .out_task_id  (out_task_id),
    .out_priority (out_priority),
    .all_empty    (all_empty),
    .total_count  (total_count),
    .level_count  (level_count)
  );

endmodule

`default_nettype wire
